[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion forms for the parser port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/s2u64_pkg.sv]
// ----------------------------------------------------------------------------
// String to u64 parser package
// Types, codes, character constants and the digit decoder of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2u64_pkg;

	localparam int POS_WIDTH_DEF = 16;

	localparam logic [5:0] MAX_BASE  = 6'(10 + 8'("Z") - 8'("A") + 1);
	localparam logic [5:0] NOT_DIGIT = 6'd63;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_ONE  = 6'd1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DIGIT = 2'd1;
	localparam logic [1:0] ST_BAD_BASE = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic        emit;
		logic [63:0] value;
		logic [15:0] stop_index;
		logic [1:0]  status;
	} res_t;

	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [5:0] d;
		d = NOT_DIGIT;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = 6'(c - CH_ZERO);
		end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			d = 6'(c - CH_UPPER_A + 8'd10);
		end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			d = 6'(c - CH_LOWER_A + 8'd10);
		end
		return d;
	endfunction

endpackage

[rtl/s2u64_mac.sv]
// ----------------------------------------------------------------------------
// Digit multiply-add
// Computes acc * base + digit and flags a result that does not fit 64 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2u64_mac (
	input  logic [63:0] acc,
	input  logic [5:0]  base,
	input  logic [5:0]  digit,
	output logic [63:0] sum,
	output logic        ovf
);

	logic [69:0] prod;
	logic [70:0] total;

	assign prod  = 70'(acc) * 70'(base);
	assign total = 71'(prod) + 71'(digit);
	assign sum   = total[63:0];
	assign ovf   = |total[70:64];

endmodule

[rtl/s2u64_core.sv]
// ----------------------------------------------------------------------------
// Parser core
// Phase sequencer and number state; processes one character per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2u64_core #(
	parameter int POS_WIDTH = s2u64_pkg::POS_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        ch,
	input  logic              first,
	input  logic [5:0]        radix,
	output s2u64_pkg::res_t   res
);

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	s2u64_pkg::phase_t      phase_q, phase_d, cur_phase;
	logic [63:0]            acc_q, acc_d, cur_acc;
	logic                   ovf_q, ovf_d, cur_ovf;
	logic                   neg_q, neg_d, cur_neg;
	logic [5:0]             base_q, base_d, cur_base;
	logic [POS_WIDTH-1:0]   pos_q, pos_d, cur_pos;

	logic                   bad_radix;
	logic                   live;
	logic [5:0]             dig;
	logic                   is_ws;
	logic                   is_sign;
	logic                   is_x;
	logic                   zero_pfx;
	logic [5:0]             fd_base;
	logic [5:0]             z_base;
	logic [5:0]             add_base;
	logic                   add_stop;
	logic                   fd_stop;
	logic [63:0]            mac_sum;
	logic                   mac_ovf;
	logic [63:0]            fin_value;
	logic [31:0]            pos_wide;
	logic [15:0]            stop_sat;

	always_comb begin
		bad_radix = (radix == s2u64_pkg::BASE_ONE) || (radix > s2u64_pkg::MAX_BASE);
		cur_phase = first ? s2u64_pkg::PH_SPACE : phase_q;
		cur_base  = first ? radix : base_q;
		cur_acc   = first ? 64'd0 : acc_q;
		cur_ovf   = first ? 1'b0 : ovf_q;
		cur_neg   = first ? 1'b0 : neg_q;
		if (first) begin
			cur_pos = '0;
		end else if (pos_q == POS_MAX) begin
			cur_pos = pos_q;
		end else begin
			cur_pos = pos_q + POS_WIDTH'(1);
		end
		if (first) begin
			live = !bad_radix;
		end else begin
			live = (phase_q != s2u64_pkg::PH_IDLE) && (phase_q != s2u64_pkg::PH_DONE);
		end
		dig      = s2u64_pkg::digit_value(ch);
		is_ws    = (ch == s2u64_pkg::CH_SPACE) ||
			(ch inside {[s2u64_pkg::CH_TAB:s2u64_pkg::CH_CR]});
		is_sign  = (ch == s2u64_pkg::CH_MINUS) || (ch == s2u64_pkg::CH_PLUS);
		is_x     = (ch == s2u64_pkg::CH_LOWER_X) || (ch == s2u64_pkg::CH_UPPER_X);
		zero_pfx = (ch == s2u64_pkg::CH_ZERO) &&
			((cur_base == s2u64_pkg::BASE_AUTO) || (cur_base == s2u64_pkg::BASE_HEX));
		fd_base  = (cur_base == s2u64_pkg::BASE_AUTO) ? s2u64_pkg::BASE_DEC : cur_base;
		z_base   = (cur_base == s2u64_pkg::BASE_AUTO) ? s2u64_pkg::BASE_OCT : cur_base;
		add_base = (cur_phase == s2u64_pkg::PH_ZERO) ? z_base : cur_base;
		add_stop = dig >= add_base;
		fd_stop  = dig >= fd_base;
		if (cur_ovf) begin
			fin_value = '1;
		end else if (cur_neg) begin
			fin_value = ~cur_acc + 64'd1;
		end else begin
			fin_value = cur_acc;
		end
		pos_wide = 32'(cur_pos);
		stop_sat = (pos_wide > 32'h0000FFFF) ? 16'hFFFF : pos_wide[15:0];
	end

	s2u64_mac u_mac (
		.acc   (cur_acc),
		.base  (add_base),
		.digit (dig),
		.sum   (mac_sum),
		.ovf   (mac_ovf)
	);

	always_comb begin
		phase_d = phase_q;
		if (en && first && bad_radix) begin
			phase_d = s2u64_pkg::PH_DONE;
		end else if (en && live) begin
			case (cur_phase)
				s2u64_pkg::PH_SPACE: begin
					if (is_ws) begin
						phase_d = s2u64_pkg::PH_SPACE;
					end else if (is_sign) begin
						phase_d = s2u64_pkg::PH_SIGNED;
					end else if (zero_pfx) begin
						phase_d = s2u64_pkg::PH_ZERO;
					end else if (fd_stop) begin
						phase_d = s2u64_pkg::PH_DONE;
					end else begin
						phase_d = s2u64_pkg::PH_DIGITS;
					end
				end
				s2u64_pkg::PH_SIGNED: begin
					if (zero_pfx) begin
						phase_d = s2u64_pkg::PH_ZERO;
					end else if (fd_stop) begin
						phase_d = s2u64_pkg::PH_DONE;
					end else begin
						phase_d = s2u64_pkg::PH_DIGITS;
					end
				end
				s2u64_pkg::PH_ZERO: begin
					if (is_x) begin
						phase_d = s2u64_pkg::PH_PREFIX;
					end else if (add_stop) begin
						phase_d = s2u64_pkg::PH_DONE;
					end else begin
						phase_d = s2u64_pkg::PH_DIGITS;
					end
				end
				s2u64_pkg::PH_PREFIX: begin
					if (dig >= s2u64_pkg::BASE_HEX) begin
						phase_d = s2u64_pkg::PH_DONE;
					end else begin
						phase_d = s2u64_pkg::PH_DIGITS;
					end
				end
				s2u64_pkg::PH_DIGITS: begin
					if (add_stop) begin
						phase_d = s2u64_pkg::PH_DONE;
					end else begin
						phase_d = s2u64_pkg::PH_DIGITS;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		acc_d  = acc_q;
		ovf_d  = ovf_q;
		neg_d  = neg_q;
		base_d = base_q;
		pos_d  = pos_q;
		res    = '{emit: 1'b0, value: 64'd0, stop_index: 16'd0, status: s2u64_pkg::ST_OK};
		if (en && first && bad_radix) begin
			acc_d      = cur_acc;
			ovf_d      = cur_ovf;
			neg_d      = cur_neg;
			base_d     = cur_base;
			pos_d      = cur_pos;
			res.emit   = 1'b1;
			res.status = s2u64_pkg::ST_BAD_BASE;
		end else if (en && live) begin
			acc_d  = cur_acc;
			ovf_d  = cur_ovf;
			neg_d  = cur_neg;
			base_d = cur_base;
			pos_d  = cur_pos;
			case (cur_phase)
				s2u64_pkg::PH_SPACE, s2u64_pkg::PH_SIGNED: begin
					if ((cur_phase == s2u64_pkg::PH_SPACE) && is_ws) begin
						acc_d = cur_acc;
					end else if ((cur_phase == s2u64_pkg::PH_SPACE) && is_sign) begin
						neg_d = (ch == s2u64_pkg::CH_MINUS);
					end else if (zero_pfx) begin
						acc_d = 64'd0;
					end else begin
						base_d = fd_base;
						if (fd_stop) begin
							res.emit   = 1'b1;
							res.status = s2u64_pkg::ST_NO_DIGIT;
						end else begin
							acc_d = 64'(dig);
						end
					end
				end
				s2u64_pkg::PH_ZERO, s2u64_pkg::PH_DIGITS: begin
					if ((cur_phase == s2u64_pkg::PH_ZERO) && is_x) begin
						base_d = s2u64_pkg::BASE_HEX;
					end else begin
						base_d = add_base;
						if (add_stop) begin
							res.emit       = 1'b1;
							res.value      = fin_value;
							res.stop_index = stop_sat;
							res.status     = cur_ovf ? s2u64_pkg::ST_OVERFLOW
								: s2u64_pkg::ST_OK;
						end else if (mac_ovf) begin
							ovf_d = 1'b1;
						end else begin
							acc_d = mac_sum;
						end
					end
				end
				s2u64_pkg::PH_PREFIX: begin
					if (dig >= s2u64_pkg::BASE_HEX) begin
						res.emit   = 1'b1;
						res.status = s2u64_pkg::ST_NO_DIGIT;
					end else begin
						acc_d = 64'(dig);
					end
				end
				default: begin
					acc_d = cur_acc;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= s2u64_pkg::PH_IDLE;
			acc_q   <= 64'd0;
			ovf_q   <= 1'b0;
			neg_q   <= 1'b0;
			base_q  <= s2u64_pkg::BASE_DEC;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			pos_q   <= pos_d;
		end
	end

endmodule

[rtl/string_to_u64_parser.sv]
// ----------------------------------------------------------------------------
// String to u64 parser, one character per cycle with a registered result.
// Both rates hold only while a pending result is not stalled by out_ready.
// Throughput: one request per cycle, set by the single multiply-add feedback loop.
// Reset: clears all control state, sets the radix register to ten, phase to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_u64_parser #(
	parameter int POS_WIDTH = s2u64_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  radix,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [15:0] stop_index,
	output logic [1:0]  status
);

	logic [5:0]        radix_reg_q;
	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              first_s1;
	logic              adv;
	s2u64_pkg::res_t   res;
	logic              out_valid_q;
	logic [63:0]       value_q;
	logic [15:0]       stop_q;
	logic [1:0]        status_q;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_reg_q <= s2u64_pkg::BASE_DEC;
		end else if (cfg_valid && cfg_ready) begin
			radix_reg_q <= radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1    <= ch;
			first_s1 <= first;
		end
	end

	s2u64_core #(
		.POS_WIDTH (POS_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ch     (ch_s1),
		.first  (first_s1),
		.radix  (radix_reg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			value_q  <= res.value;
			stop_q   <= res.stop_index;
			status_q <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign stop_index = stop_q;
	assign status     = status_q;

endmodule

[rtl/s2u64_chk.sv]
// ----------------------------------------------------------------------------
// Parser port checker
// Checks result hold behavior and status-dependent result values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s2u64_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value,
	input logic [15:0] stop_index,
	input logic [1:0]  status
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result request dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(value) && $stable(stop_index) && $stable(status), "result payload changed while stalled")
	`ASSERT_IMPLY(a_no_number, clk, arst_n, out_valid && ((status == s2u64_pkg::ST_NO_DIGIT) || (status == s2u64_pkg::ST_BAD_BASE)), (value == 64'd0) && (stop_index == 16'd0), "no-number result carries a value or index")
	`ASSERT_IMPLY(a_ovf_sat, clk, arst_n, out_valid && (status == s2u64_pkg::ST_OVERFLOW), (value == '1) && (stop_index != 16'd0), "overflow result not saturated")

endmodule

bind string_to_u64_parser s2u64_chk u_chk (.*);

[test/tb_string_to_u64_parser.sv]
// ----------------------------------------------------------------------------
// String to u64 parser testbench
// Sends strings one character per request and checks every converted value,
// stop index and status against a built-in model of the parser. The run covers
// several radix settings, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_string_to_u64_parser;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BUDGET = 95;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} char_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] stop_index;
		logic [1:0]  status;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  radix = s2u64_pkg::BASE_DEC;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ch = '0;
	logic        first = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic [15:0] stop_index;
	logic [1:0]  status;

	char_req_t     char_queue[$];
	parse_result_t awaited_results[$];
	int            error_count = 0;
	int            cycles = 0;
	int unsigned   tx_wait = 0;
	int unsigned   rx_wait = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	bit            squeeze = 1'b0;
	bit            calm = 1'b0;

	logic [5:0]        base_setting = s2u64_pkg::BASE_DEC;
	s2u64_pkg::phase_t ph = s2u64_pkg::PH_IDLE;
	logic [63:0]       acc = '0;
	logic              ovf = 1'b0;
	logic              neg = 1'b0;
	logic [5:0]        abase = s2u64_pkg::BASE_DEC;
	logic [15:0]       pos = '0;

	string_to_u64_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.radix      (radix),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.first      (first),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.stop_index (stop_index),
		.status     (status)
	);

	always #5 clk = ~clk;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		if (c inside {[s2u64_pkg::CH_ZERO:s2u64_pkg::CH_NINE]})
			return 6'(c - s2u64_pkg::CH_ZERO);
		if (c inside {[s2u64_pkg::CH_UPPER_A:s2u64_pkg::CH_UPPER_Z]})
			return 6'(c - s2u64_pkg::CH_UPPER_A + 8'd10);
		if (c inside {[s2u64_pkg::CH_LOWER_A:s2u64_pkg::CH_LOWER_Z]})
			return 6'(c - s2u64_pkg::CH_LOWER_A + 8'd10);
		return s2u64_pkg::NOT_DIGIT;
	endfunction

	function automatic bit close_number(input logic [63:0] v, input logic [15:0] idx,
			input logic [1:0] st, output parse_result_t r);
		r.value = v;
		r.stop_index = idx;
		r.status = st;
		ph = s2u64_pkg::PH_DONE;
		return 1'b1;
	endfunction

	function automatic bit take_digit(input logic [7:0] c, output parse_result_t r);
		logic [5:0]  d;
		logic [63:0] lim;
		logic [63:0] rem;
		d = digit_of(c);
		r = '0;
		if (d >= abase) begin
			if (ovf)
				return close_number('1, pos, s2u64_pkg::ST_OVERFLOW, r);
			return close_number(neg ? 64'd0 - acc : acc, pos, s2u64_pkg::ST_OK, r);
		end
		lim = 64'hFFFF_FFFF_FFFF_FFFF / 64'(abase);
		rem = 64'hFFFF_FFFF_FFFF_FFFF % 64'(abase);
		if (acc < lim || (acc == lim && 64'(d) <= rem))
			acc = acc * 64'(abase) + 64'(d);
		else
			ovf = 1'b1;
		return 1'b0;
	endfunction

	function automatic bit lead_digit(input logic [7:0] c, output parse_result_t r);
		logic [5:0] d;
		r = '0;
		if (c == s2u64_pkg::CH_ZERO &&
				(abase == s2u64_pkg::BASE_AUTO || abase == s2u64_pkg::BASE_HEX)) begin
			acc = '0;
			ph = s2u64_pkg::PH_ZERO;
			return 1'b0;
		end
		if (abase == s2u64_pkg::BASE_AUTO)
			abase = s2u64_pkg::BASE_DEC;
		d = digit_of(c);
		if (d >= abase)
			return close_number('0, '0, s2u64_pkg::ST_NO_DIGIT, r);
		acc = 64'(d);
		ph = s2u64_pkg::PH_DIGITS;
		return 1'b0;
	endfunction

	function automatic bit parse_char(input logic [7:0] c, input logic f,
			output parse_result_t r);
		r = '0;
		if (f) begin
			acc = '0;
			ovf = 1'b0;
			neg = 1'b0;
			pos = '0;
			abase = base_setting;
			if (abase == s2u64_pkg::BASE_ONE || abase > s2u64_pkg::MAX_BASE)
				return close_number('0, '0, s2u64_pkg::ST_BAD_BASE, r);
			ph = s2u64_pkg::PH_SPACE;
		end else begin
			if (ph == s2u64_pkg::PH_IDLE || ph == s2u64_pkg::PH_DONE)
				return 1'b0;
			if (pos != 16'hFFFF)
				pos = pos + 16'd1;
		end
		case (ph)
			s2u64_pkg::PH_SPACE: begin
				if (c == s2u64_pkg::CH_SPACE ||
						(c inside {[s2u64_pkg::CH_TAB:s2u64_pkg::CH_CR]}))
					return 1'b0;
				if (c == s2u64_pkg::CH_MINUS || c == s2u64_pkg::CH_PLUS) begin
					neg = (c == s2u64_pkg::CH_MINUS);
					ph = s2u64_pkg::PH_SIGNED;
					return 1'b0;
				end
				return lead_digit(c, r);
			end
			s2u64_pkg::PH_SIGNED: return lead_digit(c, r);
			s2u64_pkg::PH_ZERO: begin
				if (c == s2u64_pkg::CH_LOWER_X || c == s2u64_pkg::CH_UPPER_X) begin
					abase = s2u64_pkg::BASE_HEX;
					ph = s2u64_pkg::PH_PREFIX;
					return 1'b0;
				end
				if (abase == s2u64_pkg::BASE_AUTO)
					abase = s2u64_pkg::BASE_OCT;
				ph = s2u64_pkg::PH_DIGITS;
				return take_digit(c, r);
			end
			s2u64_pkg::PH_PREFIX: begin
				if (digit_of(c) >= s2u64_pkg::BASE_HEX)
					return close_number('0, '0, s2u64_pkg::ST_NO_DIGIT, r);
				acc = 64'(digit_of(c));
				ph = s2u64_pkg::PH_DIGITS;
				return 1'b0;
			end
			s2u64_pkg::PH_DIGITS: return take_digit(c, r);
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		int k;
		k = $urandom_range(0, 5);
		return (k == 0) ? s2u64_pkg::CH_SPACE : 8'(s2u64_pkg::CH_TAB + k - 1);
	endfunction

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		if (d < 6'd10)
			return 8'(s2u64_pkg::CH_ZERO + d);
		if ($urandom_range(0, 1) == 0)
			return 8'(s2u64_pkg::CH_UPPER_A + d - 6'd10);
		return 8'(s2u64_pkg::CH_LOWER_A + d - 6'd10);
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic f);
		char_queue.push_back({c, f});
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == 0);
	endtask

	task automatic queue_random_string(output int counted);
		logic [7:0] s[$];
		logic [5:0] eb;
		logic [5:0] d;
		int         k;
		int         nd;
		eb = (base_setting >= 6'd2 && base_setting <= s2u64_pkg::MAX_BASE) ?
			base_setting : s2u64_pkg::BASE_DEC;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				s.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					s.push_back(blank_char());
			k = $urandom_range(0, 3);
			if (k == 0)
				s.push_back(s2u64_pkg::CH_PLUS);
			else if (k == 1)
				s.push_back(s2u64_pkg::CH_MINUS);
			if ($urandom_range(0, 11) == 0)
				s.push_back(blank_char());
			if (base_setting == s2u64_pkg::BASE_AUTO) begin
				k = $urandom_range(0, 2);
				if (k == 0) begin
					s.push_back(s2u64_pkg::CH_ZERO);
					s.push_back($urandom_range(0, 1) ? s2u64_pkg::CH_LOWER_X
						: s2u64_pkg::CH_UPPER_X);
					eb = s2u64_pkg::BASE_HEX;
				end else if (k == 1) begin
					s.push_back(s2u64_pkg::CH_ZERO);
					eb = s2u64_pkg::BASE_OCT;
				end
			end else if (base_setting == s2u64_pkg::BASE_HEX &&
					$urandom_range(0, 1) == 0) begin
				s.push_back(s2u64_pkg::CH_ZERO);
				s.push_back($urandom_range(0, 1) ? s2u64_pkg::CH_LOWER_X
					: s2u64_pkg::CH_UPPER_X);
			end
			k = $urandom_range(0, 9);
			nd = (k == 0) ? 0 : (k == 1) ? $urandom_range(13, 70) : $urandom_range(1, 12);
			repeat (nd) begin
				if ($urandom_range(0, 19) == 0)
					d = 6'($urandom_range(0, 35));
				else
					d = 6'($urandom_range(0, eb - 1));
				s.push_back(digit_char(d));
			end
			if ($urandom_range(0, 5) != 0)
				s.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				s.push_back(8'($urandom_range(0, 255)));
		counted = s.size();
		foreach (s[i])
			queue_char(s[i], i == 0);
	endtask

	task automatic settle();
		while (char_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [5:0] v);
		settle();
		cfg_valid <= 1'b1;
		radix <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_setting = v;
	endtask

	always @(posedge clk or negedge arst_n) begin : tx_side
		parse_result_t r;
		char_req_t     req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			first <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid && parse_char(ch, first, r))
				awaited_results.push_back(r);
			if (tx_wait != 0) begin
				tx_wait <= tx_wait - 1;
				in_valid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				req = char_queue.pop_front();
				in_valid <= 1'b1;
				ch <= req.ch;
				first <= req.first;
				tx_wait <= calm ? 0 : $urandom_range(0, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rx_side
		parse_result_t exp_r;
		int unsigned   w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			w = rx_wait;
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: value %h stop_index %0d status %0d",
						value, stop_index, status);
					error_count++;
				end else begin
					exp_r = awaited_results.pop_front();
					if (value !== exp_r.value) begin
						$error("value: expected %h, actual %h", exp_r.value, value);
						error_count++;
					end
					if (stop_index !== exp_r.stop_index) begin
						$error("stop_index: expected %0d, actual %0d",
							exp_r.stop_index, stop_index);
						error_count++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, actual %0d", exp_r.status, status);
						error_count++;
					end
				end
				w = calm ? 0 : $urandom_range(0, 7);
			end else if (w != 0 && out_valid) begin
				w = w - 1;
			end
			rx_wait <= w;
			out_ready <= (w == 0) && (hold_left == 0);
		end
	end

	// A single long output stall lets the parser fill up and push back on requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (squeeze && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [5:0] phase_radix[13];
		int         budget;
		int         n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_char(s2u64_pkg::CH_NINE, 1'b0);
		queue_char(s2u64_pkg::CH_SPACE, 1'b0);
		queue_text("18446744073709551615 ");
		queue_text("18446744073709551616;");
		queue_text(" \t\013\015+42x");
		queue_text("-1,");
		queue_text("- 5");
		queue_text("abc");
		queue_text("12");
		queue_text("7.");
		queue_text("5;9");
		write_radix(s2u64_pkg::BASE_AUTO);
		queue_text("0x1F ");
		queue_text("0Xg");
		queue_text("017 ");
		queue_text("09");
		queue_text("-0x10 ");
		queue_text("0");
		queue_text("+0 ");
		write_radix(s2u64_pkg::BASE_HEX);
		queue_text("0xff.");
		queue_text("FF+");
		queue_text("0z");
		write_radix(s2u64_pkg::BASE_ONE);
		queue_text("5");
		write_radix(6'd37);
		queue_text("5");
		write_radix(6'd63);
		queue_text("1");
		write_radix(s2u64_pkg::MAX_BASE);
		queue_text("zZ!");
		write_radix(6'd2);
		queue_text("1012");

		phase_radix = '{s2u64_pkg::BASE_AUTO, s2u64_pkg::BASE_HEX, 6'd2,
			s2u64_pkg::MAX_BASE, s2u64_pkg::BASE_OCT, s2u64_pkg::BASE_DEC,
			s2u64_pkg::BASE_ONE, 6'd37, 6'd63, 6'($urandom_range(2, 35)),
			6'($urandom_range(0, 63)), s2u64_pkg::BASE_AUTO, s2u64_pkg::MAX_BASE};
		foreach (phase_radix[p]) begin
			write_radix(phase_radix[p]);
			calm = (p % 4 == 1);
			if (p == 1)
				squeeze = 1'b1;
			budget = PHASE_BUDGET;
			while (budget > 0) begin
				queue_random_string(n);
				budget -= n;
			end
		end
		settle();

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
